### rtl/amd_pkg.sv
// Shared types, constants and the CORDIC angle table for the affine matrix decomposer.
package amd_pkg;

   localparam int DATA_W  = 32;
   localparam int UNIT_W  = 18;
   localparam int ANGLE_W = 19;
   localparam int Z_W     = 20;
   localparam int CORD_W  = 36;
   localparam int THR_W   = 16;

   localparam logic [16:0]          UNIT_ONE  = 17'd65536;
   localparam logic signed [Z_W-1:0] HALF_PI_Q = 20'sd102944;
   localparam logic signed [Z_W-1:0] PI_Q      = 20'sd205887;

   typedef logic signed [UNIT_W-1:0]  unit_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;

   typedef enum logic [1:0] {
      SEL_RY,
      SEL_RX,
      SEL_RZ
   } angle_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_M33_RD,
      ST_M33_CHK,
      ST_ZERO_OUT,
      ST_TR_RD,
      ST_TR_LD,
      ST_SQ_RD,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DV_RD,
      ST_DV_GO,
      ST_DV_WAIT,
      ST_CS_MUL,
      ST_CS_SUB,
      ST_CS_GO,
      ST_CS_WAIT,
      ST_GIMBAL,
      ST_RY_GO,
      ST_RY_WAIT,
      ST_RX_GO,
      ST_RX_WAIT,
      ST_RZ_GO,
      ST_RZ_WAIT,
      ST_OUT
   } ctl_state_type;

   typedef struct packed {
      logic          rd_en;
      logic [3:0]    rd_addr;
      logic          trans_load;
      logic          sq_mul;
      logic          sq_acc;
      logic          acc_clear;
      logic          sqrt_start;
      logic          len_load;
      logic          div_start;
      logic          unit_load;
      logic          cs_mul;
      logic          cs_sub;
      logic          cs_load;
      logic          gimbal_load;
      logic          cordic_start;
      logic          angle_load;
      angle_sel_type angle_sel;
      logic          out_load;
      logic          out_zero;
      logic [1:0]    col;
      logic [1:0]    row;
   } ctl_cmd_type;

   typedef struct packed {
      logic m33_small;
      logic sqrt_done;
      logic div_done;
      logic cordic_done;
      logic gimbal;
      logic out_busy;
   } dp_status_type;

   // atan(2^-i) in Q16.16
   function automatic logic signed [Z_W-1:0] cordic_atan(input logic [3:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         4'd0:    v = 20'sd51472;
         4'd1:    v = 20'sd30386;
         4'd2:    v = 20'sd16055;
         4'd3:    v = 20'sd8150;
         4'd4:    v = 20'sd4091;
         4'd5:    v = 20'sd2047;
         4'd6:    v = 20'sd1024;
         4'd7:    v = 20'sd512;
         4'd8:    v = 20'sd256;
         4'd9:    v = 20'sd128;
         4'd10:   v = 20'sd64;
         4'd11:   v = 20'sd32;
         4'd12:   v = 20'sd16;
         4'd13:   v = 20'sd8;
         4'd14:   v = 20'sd4;
         4'd15:   v = 20'sd2;
         default: v = 20'sd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/amd_ctl.sv
// Sequencing state machine of the affine matrix decomposer.
module amd_ctl
   import amd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output logic          idle,
   output ctl_cmd_type   cmd
);

   ctl_state_type state_ff, state_in;
   logic [1:0]    col_ff, col_in;
   logic [1:0]    row_ff, row_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= 2'd0;
         row_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      case (state_ff)
         ST_IDLE:      if (start) state_in = ST_M33_RD;
         ST_M33_RD:    state_in = ST_M33_CHK;
         ST_M33_CHK: begin
            row_in   = 2'd0;
            state_in = status.m33_small ? ST_ZERO_OUT : ST_TR_RD;
         end
         ST_ZERO_OUT:  if (!status.out_busy) state_in = ST_IDLE;
         ST_TR_RD:     state_in = ST_TR_LD;
         ST_TR_LD: begin
            if (row_ff == 2'd2) begin
               row_in   = 2'd0;
               col_in   = 2'd0;
               state_in = ST_SQ_RD;
            end else begin
               row_in   = row_ff + 2'd1;
               state_in = ST_TR_RD;
            end
         end
         ST_SQ_RD:     state_in = ST_SQ_MUL;
         ST_SQ_MUL:    state_in = ST_SQ_ACC;
         ST_SQ_ACC: begin
            if (row_ff == 2'd2) begin
               row_in   = 2'd0;
               state_in = ST_SQRT_GO;
            end else begin
               row_in   = row_ff + 2'd1;
               state_in = ST_SQ_RD;
            end
         end
         ST_SQRT_GO:   state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: if (status.sqrt_done) state_in = ST_DV_RD;
         ST_DV_RD:     state_in = ST_DV_GO;
         ST_DV_GO:     state_in = ST_DV_WAIT;
         ST_DV_WAIT: begin
            if (status.div_done) begin
               if (row_ff == 2'd2) begin
                  row_in = 2'd0;
                  if (col_ff == 2'd2) begin
                     state_in = status.gimbal ? ST_GIMBAL : ST_CS_MUL;
                  end else begin
                     col_in   = col_ff + 2'd1;
                     state_in = ST_SQ_RD;
                  end
               end else begin
                  row_in   = row_ff + 2'd1;
                  state_in = ST_DV_RD;
               end
            end
         end
         ST_CS_MUL:    state_in = ST_CS_SUB;
         ST_CS_SUB:    state_in = ST_CS_GO;
         ST_CS_GO:     state_in = ST_CS_WAIT;
         ST_CS_WAIT:   if (status.sqrt_done) state_in = ST_RY_GO;
         ST_GIMBAL:    state_in = ST_RX_GO;
         ST_RY_GO:     state_in = ST_RY_WAIT;
         ST_RY_WAIT:   if (status.cordic_done) state_in = ST_RX_GO;
         ST_RX_GO:     state_in = ST_RX_WAIT;
         ST_RX_WAIT: begin
            if (status.cordic_done) state_in = status.gimbal ? ST_OUT : ST_RZ_GO;
         end
         ST_RZ_GO:     state_in = ST_RZ_WAIT;
         ST_RZ_WAIT:   if (status.cordic_done) state_in = ST_OUT;
         ST_OUT:       if (!status.out_busy) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.angle_sel = SEL_RY;
      cmd.col       = col_ff;
      cmd.row       = row_ff;
      idle          = 1'b0;
      case (state_ff)
         ST_IDLE:      idle = 1'b1;
         ST_M33_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = 4'd15;
         end
         ST_ZERO_OUT: begin
            cmd.out_load = !status.out_busy;
            cmd.out_zero = 1'b1;
         end
         ST_TR_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = {2'd3, row_ff};
         end
         ST_TR_LD:     cmd.trans_load = 1'b1;
         ST_SQ_RD, ST_DV_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = {col_ff, row_ff};
         end
         ST_SQ_MUL:    cmd.sq_mul = 1'b1;
         ST_SQ_ACC: begin
            cmd.sq_acc    = 1'b1;
            cmd.acc_clear = (row_ff == 2'd0);
         end
         ST_SQRT_GO, ST_CS_GO: cmd.sqrt_start = 1'b1;
         ST_SQRT_WAIT: cmd.len_load = status.sqrt_done;
         ST_DV_GO:     cmd.div_start = 1'b1;
         ST_DV_WAIT:   cmd.unit_load = status.div_done;
         ST_CS_MUL:    cmd.cs_mul = 1'b1;
         ST_CS_SUB:    cmd.cs_sub = 1'b1;
         ST_CS_WAIT:   cmd.cs_load = status.sqrt_done;
         ST_GIMBAL:    cmd.gimbal_load = 1'b1;
         ST_RY_GO: begin
            cmd.cordic_start = 1'b1;
            cmd.angle_sel    = SEL_RY;
         end
         ST_RY_WAIT: begin
            cmd.angle_load = status.cordic_done;
            cmd.angle_sel  = SEL_RY;
         end
         ST_RX_GO: begin
            cmd.cordic_start = 1'b1;
            cmd.angle_sel    = SEL_RX;
         end
         ST_RX_WAIT: begin
            cmd.angle_load = status.cordic_done;
            cmd.angle_sel  = SEL_RX;
         end
         ST_RZ_GO: begin
            cmd.cordic_start = 1'b1;
            cmd.angle_sel    = SEL_RZ;
         end
         ST_RZ_WAIT: begin
            cmd.angle_load = status.cordic_done;
            cmd.angle_sel  = SEL_RZ;
         end
         ST_OUT:       cmd.out_load = !status.out_busy;
         default:      cmd.out_zero = 1'b0;
      endcase
   end

endmodule

### rtl/amd_dp.sv
// Datapath of the affine matrix decomposer: element store, multiplier, root, divider, CORDIC.
module amd_dp
   import amd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [1:0]            wr_col,
   input  logic [1:0]            wr_row,
   input  logic [DATA_W-1:0]     wr_value,
   input  logic                  thr_we,
   input  logic [THR_W-1:0]      thr_value,
   input  ctl_cmd_type           cmd,
   output dp_status_type         status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  res_ok,
   output logic [DATA_W-1:0]     res_tx,
   output logic [DATA_W-1:0]     res_ty,
   output logic [DATA_W-1:0]     res_tz,
   output angle_type             res_rx,
   output angle_type             res_ry,
   output angle_type             res_rz,
   output logic [DATA_W-1:0]     res_sx,
   output logic [DATA_W-1:0]     res_sy,
   output logic [DATA_W-1:0]     res_sz
);

   // element store and its registered read port
   logic [DATA_W-1:0] mem [16];
   logic [DATA_W-1:0] rd_q_ff;
   logic [DATA_W-1:0] rd_abs;
   logic [THR_W-1:0]  thr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[{wr_col, wr_row}] <= wr_value;
      if (cmd.rd_en) rd_q_ff <= mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= 16'd1;
      else if (thr_we) thr_ff <= thr_value;
   end

   assign rd_abs = rd_q_ff[DATA_W-1] ? (~rd_q_ff + 32'd1) : rd_q_ff;

   // working registers
   logic [DATA_W-1:0] trans_ff [3];
   logic [DATA_W-1:0] len_ff [3];
   unit_type          unit_ff [9];
   logic [63:0]       mul_ff;
   logic [63:0]       acc_ff;
   logic [16:0]       cs_ff;
   angle_type         rx_ff, ry_ff, rz_ff;
   logic [16:0]       c0z_abs;
   logic [3:0]        unit_idx;

   assign c0z_abs  = unit_ff[2][UNIT_W-1] ? 17'(-unit_ff[2]) : unit_ff[2][16:0];
   assign unit_idx = 4'({2'b00, cmd.col} * 4'd3 + {2'b00, cmd.row});

   always_ff @(posedge clock) begin
      if (cmd.trans_load) trans_ff[cmd.row] <= rd_q_ff;
      if (cmd.sq_mul) mul_ff <= {32'd0, rd_abs} * {32'd0, rd_abs};
      else if (cmd.cs_mul) mul_ff <= {47'd0, c0z_abs} * {47'd0, c0z_abs};
      if (cmd.sq_acc) acc_ff <= (cmd.acc_clear ? 64'd0 : acc_ff) + mul_ff;
      else if (cmd.cs_sub) acc_ff <= 64'h1_0000_0000 - mul_ff;
   end

   // square root, two radicand bits per step
   logic        sq_busy_ff, sq_done_ff;
   logic [4:0]  sq_cnt_ff;
   logic [63:0] sq_v_ff, sq_res_ff, sq_bit_ff, sq_t;

   assign sq_t = sq_res_ff + sq_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
         sq_done_ff <= 1'b0;
      end else begin
         sq_done_ff <= 1'b0;
         if (cmd.sqrt_start) sq_busy_ff <= 1'b1;
         else if (sq_busy_ff && sq_cnt_ff == 5'd31) begin
            sq_busy_ff <= 1'b0;
            sq_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         sq_v_ff   <= acc_ff;
         sq_res_ff <= 64'd0;
         sq_bit_ff <= 64'h4000_0000_0000_0000;
         sq_cnt_ff <= 5'd0;
      end else if (sq_busy_ff) begin
         if (sq_v_ff >= sq_t) begin
            sq_v_ff   <= sq_v_ff - sq_t;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
         sq_cnt_ff <= sq_cnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.len_load) len_ff[cmd.col] <= (sq_res_ff[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                                       : sq_res_ff[31:0];
      if (cmd.cs_load) cs_ff <= sq_res_ff[16:0];
   end

   // restoring divider for (|c| << 16) / len
   logic        dv_busy_ff, dv_done_ff, dv_neg_ff, dv_ge;
   logic [5:0]  dv_cnt_ff;
   logic [47:0] dv_q_ff;
   logic [31:0] dv_rem_ff, dv_d_ff;
   logic [32:0] dv_sh;
   logic [16:0] dv_mag;
   unit_type    dv_unit;

   assign dv_sh = {dv_rem_ff, dv_q_ff[47]};
   assign dv_ge = dv_sh >= {1'b0, dv_d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_busy_ff <= 1'b0;
         dv_done_ff <= 1'b0;
      end else begin
         dv_done_ff <= 1'b0;
         if (cmd.div_start) dv_busy_ff <= 1'b1;
         else if (dv_busy_ff && dv_cnt_ff == 6'd47) begin
            dv_busy_ff <= 1'b0;
            dv_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dv_q_ff   <= {rd_abs, 16'd0};
         dv_rem_ff <= 32'd0;
         dv_d_ff   <= len_ff[cmd.col];
         dv_neg_ff <= rd_q_ff[DATA_W-1];
         dv_cnt_ff <= 6'd0;
      end else if (dv_busy_ff) begin
         dv_rem_ff <= dv_ge ? 32'(dv_sh - {1'b0, dv_d_ff}) : dv_sh[31:0];
         dv_q_ff   <= {dv_q_ff[46:0], dv_ge};
         dv_cnt_ff <= dv_cnt_ff + 6'd1;
      end
   end

   always_comb begin
      if (dv_d_ff == 32'd0) dv_mag = 17'd0;
      else if (dv_q_ff > {31'd0, UNIT_ONE}) dv_mag = UNIT_ONE;
      else dv_mag = dv_q_ff[16:0];
      dv_unit = dv_neg_ff ? -$signed({1'b0, dv_mag}) : $signed({1'b0, dv_mag});
   end

   always_ff @(posedge clock) begin
      if (cmd.unit_load) unit_ff[unit_idx] <= dv_unit;
   end

   assign status.gimbal = (c0z_abs >= UNIT_ONE);

   // CORDIC atan2 in vectoring mode
   unit_type                cy_sel, cx_sel;
   logic signed [CORD_W-1:0] cx_s, cy_s;
   logic signed [CORD_W-1:0] cx_ff, cy_ff;
   logic signed [Z_W-1:0]    cz_ff;
   logic                     cz_zero_ff, cd_busy_ff, cd_done_ff;
   logic [3:0]               cd_cnt_ff;
   logic signed [CORD_W-1:0] cdx, cdy;
   angle_type                cd_angle;

   always_comb begin
      case (cmd.angle_sel)
         SEL_RY: begin
            cy_sel = -unit_ff[2];
            cx_sel = $signed({1'b0, cs_ff});
         end
         SEL_RX: begin
            if (status.gimbal) begin
               cy_sel = -unit_ff[6];
               cx_sel = unit_ff[4];
            end else begin
               cy_sel = unit_ff[5];
               cx_sel = unit_ff[8];
            end
         end
         SEL_RZ: begin
            cy_sel = unit_ff[1];
            cx_sel = unit_ff[0];
         end
         default: begin
            cy_sel = '0;
            cx_sel = '0;
         end
      endcase
      cx_s = CORD_W'(cx_sel) <<< 14;
      cy_s = CORD_W'(cy_sel) <<< 14;
   end

   assign cdx = cy_ff >>> cd_cnt_ff;
   assign cdy = cx_ff >>> cd_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_busy_ff <= 1'b0;
         cd_done_ff <= 1'b0;
      end else begin
         cd_done_ff <= 1'b0;
         if (cmd.cordic_start) cd_busy_ff <= 1'b1;
         else if (cd_busy_ff && cd_cnt_ff == 4'd15) begin
            cd_busy_ff <= 1'b0;
            cd_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cordic_start) begin
         cz_zero_ff <= (cx_sel == '0) && (cy_sel == '0);
         cd_cnt_ff  <= 4'd0;
         if (cx_sel < 0) begin
            if (cy_sel >= 0) begin
               cx_ff <= cy_s;
               cy_ff <= -cx_s;
               cz_ff <= HALF_PI_Q;
            end else begin
               cx_ff <= -cy_s;
               cy_ff <= cx_s;
               cz_ff <= -HALF_PI_Q;
            end
         end else begin
            cx_ff <= cx_s;
            cy_ff <= cy_s;
            cz_ff <= '0;
         end
      end else if (cd_busy_ff) begin
         if (cy_ff >= 0) begin
            cx_ff <= cx_ff + cdx;
            cy_ff <= cy_ff - cdy;
            cz_ff <= cz_ff + cordic_atan(cd_cnt_ff);
         end else begin
            cx_ff <= cx_ff - cdx;
            cy_ff <= cy_ff + cdy;
            cz_ff <= cz_ff - cordic_atan(cd_cnt_ff);
         end
         cd_cnt_ff <= cd_cnt_ff + 4'd1;
      end
   end

   always_comb begin
      if (cz_zero_ff) cd_angle = '0;
      else if (cz_ff > PI_Q) cd_angle = ANGLE_W'(PI_Q);
      else if (cz_ff < -PI_Q) cd_angle = ANGLE_W'(-PI_Q);
      else cd_angle = cz_ff[ANGLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.gimbal_load) begin
         ry_ff <= unit_ff[2][UNIT_W-1] ? ANGLE_W'(HALF_PI_Q) : ANGLE_W'(-HALF_PI_Q);
         rz_ff <= '0;
      end
      if (cmd.angle_load) begin
         case (cmd.angle_sel)
            SEL_RY:  ry_ff <= cd_angle;
            SEL_RX:  rx_ff <= cd_angle;
            SEL_RZ:  rz_ff <= cd_angle;
            default: rx_ff <= cd_angle;
         endcase
      end
   end

   // output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.out_zero) begin
            res_ok <= 1'b0;
            res_tx <= '0;
            res_ty <= '0;
            res_tz <= '0;
            res_rx <= '0;
            res_ry <= '0;
            res_rz <= '0;
            res_sx <= '0;
            res_sy <= '0;
            res_sz <= '0;
         end else begin
            res_ok <= 1'b1;
            res_tx <= trans_ff[0];
            res_ty <= trans_ff[1];
            res_tz <= trans_ff[2];
            res_rx <= rx_ff;
            res_ry <= ry_ff;
            res_rz <= rz_ff;
            res_sx <= len_ff[0];
            res_sy <= len_ff[1];
            res_sz <= len_ff[2];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign status.m33_small   = ({16'd0, thr_ff} > rd_abs);
   assign status.sqrt_done   = sq_done_ff;
   assign status.div_done    = dv_done_ff;
   assign status.cordic_done = cd_done_ff;
   assign status.out_busy    = rsp_valid_ff && !rsp_ready;

endmodule

### rtl/affine_matrix_decompose.sv
// Top level of the affine matrix decomposer: stream ports, controller and datapath.
//
// The block takes a column-major 4x4 transform in signed Q16.16, one element
// per transfer on the req_ channel, and stores it by column and row. The
// transfer with req_tlast high starts the decomposition into translation,
// Euler XYZ rotation and per-column scale, delivered as one transfer on the
// rsp_ channel. rsp_tuser carries the ok flag; when |m33| is below the
// csr_ threshold, the flag is low and all other fields are zero.
// Elements are accepted in one cycle each while the block is idle. A last
// element starts a 32-step square root per column, one more for the cosine
// and three 16-step CORDIC passes outside gimbal lock (only the roll pass
// under it) and nine 48-step divisions for the unit columns, the dominant cost.
// A near-zero m33 is read and checked, and the zero result is then loaded.
// The result sits in an output register until the receiver takes it; a
// stalled receiver holds the block in its final state only while an earlier
// result is still waiting. Reset is synchronous and active high; it clears
// the control state and sets the threshold to one. Stored elements are not
// cleared and must be written before a decomposition reads them.
module affine_matrix_decompose
   import amd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] element_column, [3:2] element_row, [35:4] element_value, [39:36] zero
   input  logic [39:0]  req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] translate_x, [63:32] translate_y, [95:64] translate_z,
   // [114:96] rotate_x, [133:115] rotate_y, [152:134] rotate_z,
   // [184:153] scale_x, [216:185] scale_y, [248:217] scale_z, [255:249] zero
   output logic [255:0] rsp_tdata,
   // [0] decompose_ok
   output logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          idle;
   logic          req_fire;

   logic [DATA_W-1:0] tx, ty, tz, sx, sy, sz;
   angle_type         rx, ry, rz;

   // Elements are only taken while the controller is idle.
   assign req_tready = idle;
   assign req_fire   = req_tvalid && idle;

   amd_ctl u_ctl (
      .clock  (clock),
      .reset  (reset),
      .start  (req_fire && req_tlast),
      .status (status),
      .idle   (idle),
      .cmd    (cmd)
   );

   amd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (req_fire),
      .wr_col    (req_tdata[1:0]),
      .wr_row    (req_tdata[3:2]),
      .wr_value  (req_tdata[35:4]),
      .thr_we    (csr_wr_en),
      .thr_value (csr_wr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .res_ok    (rsp_tuser),
      .res_tx    (tx),
      .res_ty    (ty),
      .res_tz    (tz),
      .res_rx    (rx),
      .res_ry    (ry),
      .res_rz    (rz),
      .res_sx    (sx),
      .res_sy    (sy),
      .res_sz    (sz)
   );

   assign rsp_tdata = {7'd0, sz, sy, sx, rz, ry, rx, tz, ty, tx};

endmodule

### dv/tb_affine_matrix_decompose.sv
// Self-checking testbench for the affine matrix decomposer, with a predictor and random stall phases.
`timescale 1ns / 1ps

module tb_affine_matrix_decompose;
   import amd_pkg::*;

   // One matrix element as it goes out on the req_ channel.
   typedef struct {
      logic [1:0]  col;
      logic [1:0]  row;
      logic [31:0] value;
      logic        last;
   } element_type;

   // One expected decomposition, at the widths of the rsp_ fields.
   typedef struct {
      logic        ok;
      logic [31:0] tx, ty, tz;
      logic [18:0] rx, ry, rz;
      logic [31:0] sx, sy, sz;
   } pose_type;

   localparam longint UNIT = 65536;
   localparam longint HALF_PI = 102944;
   localparam longint PI_CLAMP = 205887;
   // This covers a full decomposition with margin.
   localparam int SETTLE_CYCLES = 1500;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [39:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [255:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_wr_en = 1'b0;
   logic [15:0]  csr_wr_data = '0;

   element_type pending_elements[$];
   pose_type    expected_poses[$];

   // Predictor state: the element store and the threshold register.
   longint   matrix[16];
   longint   threshold = 1;

   int       sender_idle_pct = 0;
   int       receiver_stall_pct = 0;
   int       error_count = 0;
   bit       req_taken = 1'b0;

   affine_matrix_decompose i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- arithmetic

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint angle_table(int i);
      case (i)
         0: return 51472;   1: return 30386;   2: return 16055;   3: return 8150;
         4: return 4091;    5: return 2047;    6: return 1024;    7: return 512;
         8: return 256;     9: return 128;     10: return 64;     11: return 32;
         12: return 16;     13: return 8;      14: return 4;      default: return 2;
      endcase
   endfunction

   // Vectoring CORDIC; quadrants with x < 0 are rotated by a quarter turn first.
   function automatic longint vector_angle(longint y_in, longint x_in);
      longint x, y, z, t, dx, dy;
      if (x_in == 0 && y_in == 0) return 0;
      x = x_in * 16384;
      y = y_in * 16384;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = HALF_PI;
         end else begin
            t = x; x = -y; y = t; z = -HALF_PI;
         end
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + angle_table(i);
         end else begin
            x = x - dx; y = y + dy; z = z - angle_table(i);
         end
      end
      if (z > PI_CLAMP) z = PI_CLAMP;
      if (z < -PI_CLAMP) z = -PI_CLAMP;
      return z;
   endfunction

   // Length of one column and its unit vector in Q16.16.
   function automatic longint unsigned column_length(int c, output longint unit_v[3]);
      longint unsigned sum, len, a;
      longint n;
      sum = 0;
      for (int r = 0; r < 3; r++) begin
         a = magnitude(matrix[c*4 + r]);
         sum = sum + a * a;
      end
      len = int_sqrt(sum);
      if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
      for (int r = 0; r < 3; r++) begin
         n = 0;
         if (len != 0) begin
            n = (matrix[c*4 + r] * UNIT) / longint'(len);
            if (n > UNIT) n = UNIT;
            if (n < -UNIT) n = -UNIT;
         end
         unit_v[r] = n;
      end
      return len;
   endfunction

   function automatic pose_type decompose_matrix();
      pose_type p;
      longint c0[3], c1[3], c2[3];
      longint unsigned sx, sy, sz, cs, a;
      longint rx, ry, rz;
      p = '{ok: 1'b0, tx: '0, ty: '0, tz: '0, rx: '0, ry: '0, rz: '0,
            sx: '0, sy: '0, sz: '0};
      // A near-zero m33 gives an all-zero result with the ok flag low.
      if (magnitude(matrix[15]) < longint'(threshold)) return p;
      p.ok = 1'b1;
      p.tx = matrix[12][31:0];
      p.ty = matrix[13][31:0];
      p.tz = matrix[14][31:0];
      sx = column_length(0, c0);
      sy = column_length(1, c1);
      sz = column_length(2, c2);
      if (magnitude(c0[2]) >= UNIT) begin
         // Gimbal lock: pitch is a quarter turn and yaw folds into roll.
         ry = (c0[2] > 0) ? -HALF_PI : HALF_PI;
         rx = vector_angle(-c2[0], c1[1]);
         rz = 0;
      end else begin
         a = magnitude(c0[2]);
         cs = int_sqrt((64'd1 << 32) - a * a);
         ry = vector_angle(-c0[2], longint'(cs));
         rx = vector_angle(c1[2], c2[2]);
         rz = vector_angle(c0[1], c0[0]);
      end
      p.rx = rx[18:0];
      p.ry = ry[18:0];
      p.rz = rz[18:0];
      p.sx = sx[31:0];
      p.sy = sy[31:0];
      p.sz = sz[31:0];
      return p;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(what, longint'(got), longint'(want));
   endtask

   // Accepted elements update the predictor; accepted results are compared.
   always @(posedge clock) begin
      pose_type want;
      req_taken = req_tvalid && req_tready && !reset;
      if (req_taken) begin
         matrix[req_tdata[1:0]*4 + req_tdata[3:2]] = longint'(signed'(req_tdata[35:4]));
         if (req_tlast) expected_poses.push_back(decompose_matrix());
      end
      if (rsp_tvalid && rsp_tready && !reset) begin
         if (expected_poses.size() == 0) begin
            report_mismatch("unexpected result transfer", longint'(rsp_tuser), 0);
         end else begin
            want = expected_poses.pop_front();
            check_field("decompose_ok", {31'd0, rsp_tuser}, {31'd0, want.ok});
            check_field("translate_x", rsp_tdata[31:0], want.tx);
            check_field("translate_y", rsp_tdata[63:32], want.ty);
            check_field("translate_z", rsp_tdata[95:64], want.tz);
            check_field("rotate_x", {13'd0, rsp_tdata[114:96]}, {13'd0, want.rx});
            check_field("rotate_y", {13'd0, rsp_tdata[133:115]}, {13'd0, want.ry});
            check_field("rotate_z", {13'd0, rsp_tdata[152:134]}, {13'd0, want.rz});
            check_field("scale_x", rsp_tdata[184:153], want.sx);
            check_field("scale_y", rsp_tdata[216:185], want.sy);
            check_field("scale_z", rsp_tdata[248:217], want.sz);
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // The sender holds an element until its transfer, then may pause at random.
   always @(negedge clock) begin
      element_type e;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_elements.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            e = pending_elements.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {4'd0, e.value, e.row, e.col};
            req_tlast  <= e.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_element(int col, int row, logic [31:0] value, bit last);
      element_type e;
      e.col = col[1:0];
      e.row = row[1:0];
      e.value = value;
      e.last = last;
      pending_elements.push_back(e);
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(7))
         0: return $urandom();
         1: return 32'($signed($urandom_range(400000)) - 200000);
         2: return 32'd0;
         3: return $urandom_range(1) ? 32'd65536 : -32'sd65536;
         4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         5: return 32'($signed($urandom_range(140000)) - 70000);
         6: return 32'($signed($urandom_range(4000)) - 2000);
         default: return {16'($urandom_range(65535)), 16'd0};
      endcase
   endfunction

   function automatic logic [31:0] random_m33();
      case ($urandom_range(4))
         0: return 32'd0;
         1: return 32'($signed($urandom_range(131070)) - 65535);
         2: return 32'd65536;
         3: return $urandom();
         default: return 32'($signed($urandom_range(8)) - 4);
      endcase
   endfunction

   // A whole matrix in column order; some have a pure-z first column to hit gimbal lock.
   task automatic push_matrix();
      bit gimbal;
      gimbal = ($urandom_range(9) == 0);
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (c == 3 && r == 3)
               push_element(c, r, random_m33(), 1'b1);
            else if (gimbal && c == 0)
               push_element(c, r, (r == 2) ? random_value() | 32'd1 : 32'd0, 1'b0);
            else
               push_element(c, r, random_value(), 1'b0);
         end
      end
   endtask

   task automatic push_random_traffic(int count);
      int n, k;
      n = 0;
      while (n < count) begin
         case ($urandom_range(9))
            0: begin
               // Rewrite a few elements in any order, then decompose on a random one.
               k = $urandom_range(1, 5);
               for (int i = 0; i < k; i++)
                  push_element($urandom_range(3), $urandom_range(3), random_value(),
                               i == k - 1);
               n += k;
            end
            1: begin
               push_element($urandom_range(3), $urandom_range(3), $urandom(), 1'b0);
               n += 1;
            end
            default: begin
               push_matrix();
               n += 16;
            end
         endcase
      end
   endtask

   task automatic push_directed();
      // Identity with a translation: zero angles and unit scales.
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            push_element(c, r, (c == r) ? 32'd65536 : (c == 3 ? 32'd131072 * (r + 1) : 32'd0),
                         c == 3 && r == 3);
      // Gimbal lock with c0.z positive, then negative.
      push_element(0, 0, 32'd0, 1'b0);
      push_element(0, 2, 32'd65536, 1'b1);
      push_element(0, 2, -32'sd200000, 1'b1);
      // Column 0 pointing into negative x: the CORDIC quarter-turn branch.
      push_element(0, 0, -32'sd65536, 1'b0);
      push_element(0, 2, 32'd0, 1'b0);
      push_element(0, 1, -32'sd3000, 1'b1);
      // Extreme element values and a zero column.
      push_element(1, 0, 32'h8000_0000, 1'b0);
      push_element(1, 1, 32'h7FFF_FFFF, 1'b0);
      push_element(1, 2, 32'h8000_0000, 1'b0);
      push_element(2, 0, 32'd0, 1'b0);
      push_element(2, 1, 32'd0, 1'b0);
      push_element(2, 2, 32'd0, 1'b0);
      push_element(3, 0, 32'h8000_0000, 1'b0);
      push_element(3, 1, 32'h7FFF_FFFF, 1'b1);
      // m33 of zero, then at and just above the reset threshold.
      push_element(3, 3, 32'd0, 1'b1);
      push_element(3, 3, -32'sd1, 1'b1);
      push_element(3, 3, 32'hFFFF_FFFE, 1'b1);
   endtask

   task automatic write_threshold(logic [15:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      threshold = longint'(value);
   endtask

   task automatic wait_until_drained();
      while (pending_elements.size() != 0 || req_tvalid || expected_poses.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset threshold first; the directed matrix writes every element.
      push_directed();
      push_random_traffic(350);
      wait_until_drained();

      write_threshold(16'd0);
      sender_idle_pct = 46;
      push_random_traffic(380);
      wait_until_drained();

      write_threshold(16'hFFFF);
      sender_idle_pct = 0;
      receiver_stall_pct = 46;
      push_random_traffic(380);
      wait_until_drained();

      write_threshold(16'($urandom()));
      sender_idle_pct = 8;
      receiver_stall_pct = 8;
      push_random_traffic(380);
      wait_until_drained();

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("FAIL");
      $finish;
   end

endmodule

### filelist.f
rtl/amd_pkg.sv
rtl/amd_ctl.sv
rtl/amd_dp.sv
rtl/affine_matrix_decompose.sv
dv/tb_affine_matrix_decompose.sv
